// ===== hw/rtl/bott_pkg.sv =====
// ----------------------------------------------------------------------------
// bott_pkg
// Shared widths, saturation limits and item codes for the box overlap tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package bott_pkg;

  // Widths of the beat fields, fixed by the channel definition
  localparam int EDGE_W  = 12;
  localparam int TAG_W   = 32;
  localparam int FRAME_W = 32;
  localparam int IDX_W   = 6;

  // Box position counter, saturating
  localparam int                 CNT_W     = 7;
  localparam logic [CNT_W-1:0]   COUNT_SAT = '1;
  localparam logic [IDX_W-1:0]   IDX_SAT   = '1;

  // Item codes on the func field
  localparam logic FUNC_BOX = 1'b0;
  localparam logic FUNC_EOF = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/bott_box_if.sv =====
// ----------------------------------------------------------------------------
// bott_box_if
// Input channel: one detected box or an end-of-frame marker per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bott_box_if
  import bott_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [EDGE_W-1:0] box_left;
  logic [EDGE_W-1:0] box_top;
  logic [EDGE_W-1:0] box_right;
  logic [EDGE_W-1:0] box_bottom;
  logic [TAG_W-1:0]  current_msec;

  modport source (
    output valid, func, box_left, box_top, box_right, box_bottom, current_msec,
    input  ready
  );

  modport sink (
    input  valid, func, box_left, box_top, box_right, box_bottom, current_msec,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/bott_res_if.sv =====
// ----------------------------------------------------------------------------
// bott_res_if
// Result channel: one tag record per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bott_res_if
  import bott_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TAG_W-1:0]   time_tag;
  logic               is_new;
  logic [IDX_W-1:0]   box_index;
  logic [FRAME_W-1:0] frame_number;
  logic               last;
  logic               overflow;

  modport source (
    output valid, time_tag, is_new, box_index, frame_number, last, overflow,
    input  ready
  );

  modport sink (
    input  valid, time_tag, is_new, box_index, frame_number, last, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/box_overlap_tag_tracker_core.sv =====
// A box beat is swept in S_SCAN against the P boxes kept from the previous
//   frame (P at most MAX_OBJECTS) and gives its final result from S_DONE.
// A new box is taken only back in S_IDLE; the sweep, set by the single read
//   port of the box store, reads one stored box per cycle unless stalled by the output.
// Reset clears frame count, box counts and bank select; the store needs no
//   clearing pass, as only entries written in the previous frame are read.
// ----------------------------------------------------------------------------
// box_overlap_tag_tracker_core
// Tracks bounding boxes across frames by overlap and hands out time tags.
// ----------------------------------------------------------------------------
`default_nettype none

module box_overlap_tag_tracker_core
  import bott_pkg::*;
#(
  parameter int MAX_OBJECTS = 64,
  parameter int COORD_BITS  = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bott_box_if.sink   box_i,
  bott_res_if.source res_o
);

  // Store geometry: two banks of MAX_OBJECTS entries, {tag, bottom, right, top, left}
  localparam int CW    = COORD_BITS;
  localparam int BOX_W = 4 * CW;
  localparam int DEPTH = 2 * MAX_OBJECTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = TAG_W + BOX_W;

  localparam logic [AW-1:0]    HALF = AW'(MAX_OBJECTS);
  localparam logic [CNT_W-1:0] CAP  = CNT_W'(MAX_OBJECTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Control state
  state_e             state_q, state_d;
  logic               bank_q, bank_d;
  logic [CNT_W-1:0]   prev_cnt_q, prev_cnt_d;
  logic [CNT_W-1:0]   cur_cnt_q, cur_cnt_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               rv_q, rv_d;
  logic               pend_v_q, pend_v_d;
  logic               out_v_q, out_v_d;

  // Item under work
  logic [BOX_W-1:0]   box_q, box_d;
  logic [TAG_W-1:0]   msec_q, msec_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic               ovf_q, ovf_d;
  logic [TAG_W-1:0]   pend_tag_q, pend_tag_d;

  // Output register
  logic [TAG_W-1:0]   out_tag_q, out_tag_d;
  logic               out_new_q, out_new_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [FRAME_W-1:0] out_frame_q, out_frame_d;
  logic               out_last_q, out_last_d;
  logic               out_ovf_q, out_ovf_d;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               hit;
  logic               stall;
  logic               issue;
  logic [DW-1:0]      rd_data;
  logic [TAG_W-1:0]   rd_tag;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DW-1:0]      wr_data;
  logic [IDX_W-1:0]   idx_sat;

  // --------------------------------------------------------------------------
  // Box store and overlap test
  // --------------------------------------------------------------------------
  bott_store #(
    .DEPTH (DEPTH),
    .WIDTH (DW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bott_hit #(
    .CW (CW)
  ) u_hit (
    .cur_i  (box_q),
    .prev_i (rd_data[BOX_W-1:0]),
    .hit_o  (hit)
  );

  assign rd_tag = rd_data[DW-1:BOX_W];

  // --------------------------------------------------------------------------
  // Handshake and sweep control
  // --------------------------------------------------------------------------
  // The output register frees up either empty or drained in this cycle.
  assign out_free = !out_v_q || res_o.ready;

  // A hit with a pending record in hand must push the pending one out first;
  // hold the sweep (and the read data) until the output register can take it.
  assign stall = rv_q && hit && pend_v_q && !out_free;

  assign issue = (state_q == S_SCAN) && !stall && (scan_q < prev_cnt_q);

  // bank_q selects the current half; the previous frame lives in the other one
  assign rd_addr = (bank_q ? '0 : HALF) + AW'(scan_q);
  assign wr_addr = (bank_q ? HALF : '0) + AW'(pos_q);
  assign wr_data = {(pend_v_q ? pend_tag_q : msec_q), box_q};
  assign wr_en   = (state_q == S_DONE) && out_free && !ovf_q;

  assign box_i.ready = (state_q == S_IDLE);
  assign accept      = box_i.valid && box_i.ready;

  assign idx_sat = (pos_q > CNT_W'(IDX_SAT)) ? IDX_SAT : pos_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    bank_d      = bank_q;
    prev_cnt_d  = prev_cnt_q;
    cur_cnt_d   = cur_cnt_q;
    frame_d     = frame_q;
    scan_d      = scan_q;
    rv_d        = rv_q;
    pend_v_d    = pend_v_q;
    pend_tag_d  = pend_tag_q;
    box_d       = box_q;
    msec_d      = msec_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    out_load    = 1'b0;
    out_tag_d   = out_tag_q;
    out_new_d   = out_new_q;
    out_last_d  = out_last_q;
    out_v_d     = out_v_q && !res_o.ready;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (box_i.func == FUNC_EOF) begin
            // Close the frame: current boxes become the previous set
            prev_cnt_d = (cur_cnt_q > CAP) ? CAP : cur_cnt_q;
            bank_d     = !bank_q;
            cur_cnt_d  = '0;
            frame_d    = frame_q + FRAME_W'(1);
          end else begin
            box_d    = {CW'(box_i.box_bottom), CW'(box_i.box_right),
                        CW'(box_i.box_top), CW'(box_i.box_left)};
            msec_d   = box_i.current_msec;
            pos_d    = cur_cnt_q;
            ovf_d    = (cur_cnt_q >= CAP);
            scan_d   = '0;
            rv_d     = 1'b0;
            pend_v_d = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          rv_d = issue;
          if (issue) begin
            scan_d = scan_q + CNT_W'(1);
          end
          // Each hit replaces the pending record; the older one goes out
          // as a non-final beat.
          if (rv_q && hit) begin
            if (pend_v_q) begin
              out_load   = 1'b1;
              out_tag_d  = pend_tag_q;
              out_new_d  = 1'b0;
              out_last_d = 1'b0;
            end
            pend_tag_d = rd_tag;
            pend_v_d   = 1'b1;
          end
          if (!issue) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          // Final beat: last hit, or a new tag when nothing overlapped
          out_load   = 1'b1;
          out_tag_d  = pend_v_q ? pend_tag_q : msec_q;
          out_new_d  = !pend_v_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          if (cur_cnt_q != COUNT_SAT) begin
            cur_cnt_d = cur_cnt_q + CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_v_d = 1'b1;
    end
  end

  assign out_idx_d   = out_load ? idx_sat : out_idx_q;
  assign out_frame_d = out_load ? frame_q : out_frame_q;
  assign out_ovf_d   = out_load ? ovf_q   : out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_q      <= 1'b0;
      prev_cnt_q  <= '0;
      cur_cnt_q   <= '0;
      frame_q     <= '0;
      scan_q      <= '0;
      rv_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      pend_tag_q  <= '0;
      box_q       <= '0;
      msec_q      <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_v_q     <= 1'b0;
      out_tag_q   <= '0;
      out_new_q   <= 1'b0;
      out_idx_q   <= '0;
      out_frame_q <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      prev_cnt_q  <= prev_cnt_d;
      cur_cnt_q   <= cur_cnt_d;
      frame_q     <= frame_d;
      scan_q      <= scan_d;
      rv_q        <= rv_d;
      pend_v_q    <= pend_v_d;
      pend_tag_q  <= pend_tag_d;
      box_q       <= box_d;
      msec_q      <= msec_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_v_q     <= out_v_d;
      out_tag_q   <= out_tag_d;
      out_new_q   <= out_new_d;
      out_idx_q   <= out_idx_d;
      out_frame_q <= out_frame_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.time_tag     = out_tag_q;
  assign res_o.is_new       = out_new_q;
  assign res_o.box_index    = out_idx_q;
  assign res_o.frame_number = out_frame_q;
  assign res_o.last         = out_last_q;
  assign res_o.overflow     = out_ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_prev_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_cnt_q <= CAP)
    else $error("previous box count beyond capacity");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> scan_q <= prev_cnt_q)
    else $error("sweep ran past the previous set");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> state_q == S_SCAN)
    else $error("read data pending outside the sweep");

  a_last_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |-> state_q == S_DONE)
    else $error("final beat loaded outside the closing step");

  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> state_q == S_IDLE)
    else $error("closing step did not return to idle");

endmodule

`default_nettype wire

// ===== hw/rtl/bott_store.sv =====
// ----------------------------------------------------------------------------
// bott_store
// Box store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bott_store #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 80
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold the last word when no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bott_hit.sv =====
// ----------------------------------------------------------------------------
// bott_hit
// Strict rectangle overlap test of the current box against one stored box.
// ----------------------------------------------------------------------------
`default_nettype none

module bott_hit #(
  parameter int CW = 12
) (
  input  logic [4*CW-1:0] cur_i,   // {bottom, right, top, left}
  input  logic [4*CW-1:0] prev_i,  // same packing
  output logic            hit_o
);

  logic [CW-1:0] c_l, c_t, c_r, c_b;
  logic [CW-1:0] p_l, p_t, p_r, p_b;

  assign {c_b, c_r, c_t, c_l} = cur_i;
  assign {p_b, p_r, p_t, p_l} = prev_i;

  assign hit_o = (c_l < p_r) && (c_r > p_l) && (c_t < p_b) && (c_b > p_t);

endmodule

`default_nettype wire
